>>> rtl/core/bpaq_pkg.sv
// Package with the sizes, entry type and shared constants of the alert queue.
package bpaq_pkg;

  localparam int CAPACITY = 16;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int FILL_W   = 5;

  localparam logic FUNC_PUSH = 1'b0;
  localparam logic FUNC_POP  = 1'b1;

  typedef struct packed {
    logic [1:0]  priority_val;
    logic [15:0] track;
    logic [2:0]  kind;
    logic [15:0] id;
    logic [31:0] stamp;
  } entry_t;

endpackage

>>> rtl/core/bpaq_ifs.sv
// Valid/ready channel interfaces for the request and response items of the alert queue.
interface bpaq_req_if;
  logic        valid;
  logic        ready;
  logic        func;
  logic [1:0]  priority_req;
  logic [15:0] track_number;
  logic [2:0]  alert_kind;
  logic [15:0] alert_id;
  logic [31:0] stamp;

  modport source (output valid, func, priority_req, track_number, alert_kind, alert_id, stamp,
                  input ready);
  modport sink (input valid, func, priority_req, track_number, alert_kind, alert_id, stamp,
                output ready);
endinterface

interface bpaq_rsp_if;
  logic        valid;
  logic        ready;
  logic        empty_res;
  logic        dropped;
  logic [1:0]  out_priority;
  logic [15:0] out_track;
  logic [2:0]  out_kind;
  logic [15:0] out_id;
  logic [31:0] out_stamp;
  logic [4:0]  fill;

  modport source (output valid, empty_res, dropped, out_priority, out_track, out_kind, out_id,
                  out_stamp, fill, input ready);
  modport sink (input valid, empty_res, dropped, out_priority, out_track, out_kind, out_id,
                out_stamp, fill, output ready);
endinterface

>>> rtl/core/bpaq_store.sv
// Slot memory of the alert queue: one write port and one registered read port.
module bpaq_store
  import bpaq_pkg::*;
(
  input  logic             clk,
  input  logic             we,
  input  logic [IDX_W-1:0] waddr,
  input  entry_t           wdata,
  input  logic             re,
  input  logic [IDX_W-1:0] raddr,
  output entry_t           rdata
);

  entry_t mem [CAPACITY];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/core/bpaq_cmp.sv
// Shared compare unit: decides whether a scanned slot replaces the current best.
module bpaq_cmp
  import bpaq_pkg::*;
(
  input  logic   first,
  input  entry_t cand,
  input  entry_t best,
  output logic   take
);

  logic [31:0] diff;

  // A stamp is earlier when the wrapped difference is negative.
  assign diff = cand.stamp - best.stamp;
  assign take = first
             || (cand.priority_val > best.priority_val)
             || ((cand.priority_val == best.priority_val) && diff[31]);

endmodule

>>> rtl/core/bounded_priority_alert_queue.sv
// Top level of the bounded priority alert queue: sequencer, slot memory and compare unit.
//
//   channel  direction  handshake     payload
//   req      in         valid/ready   func, priority_req, track_number, alert_kind,
//                                     alert_id, stamp
//   rsp      out        valid/ready   empty_res, dropped, out_priority, out_track,
//                                     out_kind, out_id, out_stamp, fill
//
// A push into a queue that is not full passes through the push and done states; a pop on
// an empty queue goes straight to the done state. A pop on N held entries walks every slot
// once for the scan, then the slots above winner slot b for the shift-down, both through
// the single memory read port; nothing is shifted when the winner is the top slot.
// A push into a full queue shifts all slots down first, dropping slot zero, then pushes.
// Reset clears the entry count and all control state; slot contents are left as they are.
// The next item is accepted while a result waits on rsp; the sequencer holds in its last
// state only when a new result is ready and the previous one has still not been taken.
module bounded_priority_alert_queue
  import bpaq_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  bpaq_req_if.sink         req,
  bpaq_rsp_if.source       rsp
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_SCAN  = 5'b00010,
    S_SHIFT = 5'b00100,
    S_PUSH  = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

  state_t           state;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] ptr;
  logic             rd_vld;
  logic [IDX_W-1:0] rd_idx;
  logic             is_pop;
  logic             is_empty;
  logic             drop_flag;
  entry_t           pend;
  entry_t           best;
  logic [IDX_W-1:0] best_idx;

  logic             out_valid;
  logic             out_empty;
  logic             out_dropped;
  entry_t           out_entry;
  logic [FILL_W-1:0] out_fill;

  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  entry_t           mem_wdata;
  logic             mem_re;
  entry_t           mem_rdata;
  logic             take;
  logic             accept;
  logic             walk_done;

  assign req.ready = (state == S_IDLE);
  assign accept    = req.valid && req.ready;

  // The same read port walks the slots for both the scan and the shift-down.
  assign mem_re    = ((state == S_SCAN) || (state == S_SHIFT)) && (ptr < count);
  assign walk_done = !mem_re && !rd_vld;

  // The shift writes each slot one place lower as its read data returns; the push
  // state writes the pending entry at the first free slot.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = rd_idx - 1'b1;
    mem_wdata = mem_rdata;
    if (state == S_SHIFT && rd_vld) begin
      mem_we = 1'b1;
    end else if (state == S_PUSH) begin
      mem_we    = 1'b1;
      mem_waddr = count[IDX_W-1:0];
      mem_wdata = pend;
    end
  end

  bpaq_store u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (ptr[IDX_W-1:0]),
    .rdata (mem_rdata)
  );

  bpaq_cmp u_cmp (
    .first (rd_idx == '0),
    .cand  (mem_rdata),
    .best  (best),
    .take  (take)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      ptr       <= '0;
      rd_vld    <= 1'b0;
      out_valid <= 1'b0;
      is_pop    <= 1'b0;
      is_empty  <= 1'b0;
      drop_flag <= 1'b0;
    end else begin
      rd_vld <= mem_re;
      rd_idx <= ptr[IDX_W-1:0];
      if (mem_re) begin
        ptr <= ptr + 1'b1;
      end

      // In the done state the output register is handled below.
      if (out_valid && rsp.ready && (state != S_DONE)) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (accept) begin
            pend.priority_val <= req.priority_req;
            pend.track        <= req.track_number;
            pend.kind         <= req.alert_kind;
            pend.id           <= req.alert_id;
            pend.stamp        <= req.stamp;
            is_pop            <= (req.func == FUNC_POP);
            is_empty          <= 1'b0;
            drop_flag         <= 1'b0;
            if (req.func == FUNC_POP) begin
              if (count == '0) begin
                is_empty <= 1'b1;
                state    <= S_DONE;
              end else begin
                ptr   <= '0;
                state <= S_SCAN;
              end
            end else if (count >= CNT_W'(CAPACITY)) begin
              // Full: drop slot zero by shifting every other slot down.
              drop_flag <= 1'b1;
              ptr       <= CNT_W'(1);
              best_idx  <= '0;
              state     <= S_SHIFT;
            end else begin
              state <= S_PUSH;
            end
          end
        end
        S_SCAN: begin
          if (rd_vld && take) begin
            best     <= mem_rdata;
            best_idx <= rd_idx;
          end
          if (walk_done) begin
            ptr   <= CNT_W'(best_idx) + 1'b1;
            state <= S_SHIFT;
          end
        end
        S_SHIFT: begin
          if (walk_done) begin
            count <= count - 1'b1;
            state <= is_pop ? S_DONE : S_PUSH;
          end
        end
        S_PUSH: begin
          count <= count + 1'b1;
          state <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid || rsp.ready) begin
            out_valid   <= 1'b1;
            out_empty   <= is_empty;
            out_dropped <= drop_flag;
            out_entry   <= (is_pop && !is_empty) ? best : '0;
            out_fill    <= FILL_W'(count);
            state       <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign rsp.valid        = out_valid;
  assign rsp.empty_res    = out_empty;
  assign rsp.dropped      = out_dropped;
  assign rsp.out_priority = out_entry.priority_val;
  assign rsp.out_track    = out_entry.track;
  assign rsp.out_kind     = out_entry.kind;
  assign rsp.out_id       = out_entry.id;
  assign rsp.out_stamp    = out_entry.stamp;
  assign rsp.fill         = out_fill;

endmodule

>>> rtl/core/bpaq_checker.sv
// Port-level checker for the alert queue and the bind that attaches it to the top level.
module bpaq_checker
  import bpaq_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        rsp_valid,
  input logic        rsp_ready,
  input logic        empty_res,
  input logic        dropped,
  input logic [31:0] out_stamp,
  input logic [4:0]  fill
);

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(out_stamp) && $stable(fill))
    else $error("response item changed while stalled");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> fill <= FILL_W'(CAPACITY))
    else $error("fill exceeds capacity");

  a_empty_pop: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && empty_res |-> fill == '0 && !dropped && out_stamp == '0)
    else $error("empty pop reported entries");

  a_drop_full: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && dropped |-> fill == FILL_W'(CAPACITY) && !empty_res)
    else $error("drop reported on a queue that was not full");

endmodule

bind bounded_priority_alert_queue bpaq_checker u_bpaq_checker (
  .clk       (clk),
  .rst       (rst),
  .rsp_valid (rsp.valid),
  .rsp_ready (rsp.ready),
  .empty_res (rsp.empty_res),
  .dropped   (rsp.dropped),
  .out_stamp (rsp.out_stamp),
  .fill      (rsp.fill)
);
